// ----- hw/rtl/moving_average_spike_reject_unit_assert.svh -----
// Assertion macros for the moving average spike reject unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MOVING_AVERAGE_SPIKE_REJECT_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_SPIKE_REJECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSR_ASSERT_IMPLY(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("moving average spike reject: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSR_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("moving average spike reject: next-cycle check failed");

`endif

// ----- hw/rtl/msr_pkg.sv -----
// Shared constants and types for the moving average spike reject unit.
// Used by the top level, msr_window and msr_spike; depends on nothing.
package msr_pkg;

  localparam int WINDOW       = 50;
  localparam int CHANNELS     = 6;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 11;
  localparam int THR_W        = 11;
  localparam int SUM_W        = 17;
  localparam int THRESH_RESET = 30;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int DEPTH      = CHANNELS * WINDOW;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int LIMIT_W    = THR_W + $clog2(WINDOW);
  localparam int DIFF_W     = SUM_W + 1;
  localparam int CMP_W      = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;
  localparam int IN_DATA_W  = ((CH_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CH_W + 2 * SUM_W + 7) / 8) * 8;

  typedef struct packed {
    logic                       valid;
    logic                       in_range;
    logic                       filled;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]          addr;
  } msr_item_t;

endpackage

// ----- hw/rtl/moving_average_spike_reject_unit.sv -----
// Top level of the per-channel moving average with spike rejection.
// Uses msr_pkg, msr_window, msr_spike and the assertion header.
//
//   Channel   Direction  Handshake          Contents
//   in_       slave      tvalid / tready    channel, sample
//   out_      master     tvalid / tready    channel_out, sums; tuser = spike flag
//   cfg_      slave      valid / ready      spike threshold
//
// An accepted input word is registered together with its sample RAM read; the
// sum update and spike compare are then registered into the result word.
// One word per cycle is sustained while the output is not stalled; consecutive words of the same channel need
// no bubble because the ring pointer advances at accept time.
// Reset is synchronous and needs no clearing pass: a per-channel fill flag
// makes unwritten ring slots read as zero.
// Input ready drops only while a result word is stalled at the output.
`include "moving_average_spike_reject_unit_assert.svh"

module moving_average_spike_reject_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] channel, [13:3] sample, [15:14] zero.
  input  logic [msr_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] channel_out, [19:3] average_scaled, [36:20] filtered_scaled, [39:37] zero.
  output logic [msr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] spike_rejected.
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msr_pkg::THR_W-1:0]          cfg_data
);
  import msr_pkg::*;

  logic [LIMIT_W-1:0]         limit_r;
  logic                       accept;
  logic                       take;
  msr_item_t                  item;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic [CH_W-1:0]            out_ch;
  logic signed [SUM_W-1:0]    out_avg;
  logic signed [SUM_W-1:0]    out_filt;
  logic                       out_rej;

  assign cfg_ready = 1'b1;
  assign in_tready = !item.valid || take;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(THRESH_RESET * WINDOW);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= LIMIT_W'(LIMIT_W'(cfg_data) * LIMIT_W'(WINDOW));
    end
  end

  msr_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_ch      (in_tdata[CH_W-1:0]),
    .in_sample  ($signed(in_tdata[CH_W+SAMPLE_W-1:CH_W])),
    .take       (take),
    .item       (item),
    .old_sample (old_sample)
  );

  msr_spike u_spike (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .old_sample (old_sample),
    .limit      (limit_r),
    .out_ready  (out_tready),
    .take       (take),
    .out_valid  (out_tvalid),
    .out_ch     (out_ch),
    .out_avg    (out_avg),
    .out_filt   (out_filt),
    .out_rej    (out_rej)
  );

  assign out_tdata = OUT_DATA_W'({out_filt, out_avg, out_ch});
  assign out_tuser = out_rej;

  `MSR_ASSERT_IMPLY(a_stall_only_on_output, !in_tready, out_tvalid && !out_tready)
  `MSR_ASSERT_IMPLY(a_reject_holds_other, out_tvalid && out_rej, out_filt != out_avg)
  `MSR_ASSERT_IMPLY(a_pass_tracks_avg, out_tvalid && !out_rej, out_filt == out_avg)
  `MSR_ASSERT_NEXT(a_take_fills_output, take, out_tvalid)

endmodule

// ----- hw/rtl/msr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the per-channel sample rings.
module msr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/msr_window.sv -----
// Ring pointers, fill flags, sample RAM and the input register stage.
// Uses msr_pkg and msr_ram.
module msr_window (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [msr_pkg::CH_W-1:0]           in_ch,
  input  logic signed [msr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               take,
  output msr_pkg::msr_item_t                 item,
  output logic signed [msr_pkg::SAMPLE_W-1:0] old_sample
);
  import msr_pkg::*;

  logic [SLOT_W-1:0]   slot_r   [CHANNELS];
  logic [CHANNELS-1:0] filled_r;
  msr_item_t           item_r;

  logic                in_range;
  logic [CH_IDX_W-1:0] idx;
  logic [SLOT_W-1:0]   slot_cur;
  logic                wrap;
  logic [ADDR_W-1:0]   addr;
  logic [SAMPLE_W-1:0] rdata;

  assign in_range = ({1'b0, in_ch} < (CH_W + 1)'(CHANNELS));
  assign idx      = in_ch[CH_IDX_W-1:0];
  assign slot_cur = in_range ? slot_r[idx] : '0;
  assign wrap     = (slot_cur == SLOT_W'(WINDOW - 1));
  assign addr     = ADDR_W'(ADDR_W'(in_ch) * ADDR_W'(WINDOW)) + ADDR_W'(slot_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_r[i] <= '0;
      end
      filled_r     <= '0;
      item_r.valid <= 1'b0;
    end else begin
      if (accept && in_range) begin
        slot_r[idx] <= wrap ? '0 : slot_cur + SLOT_W'(1);
        if (wrap) begin
          filled_r[idx] <= 1'b1;
        end
      end
      if (accept) begin
        item_r.valid    <= 1'b1;
        item_r.in_range <= in_range;
        item_r.filled   <= in_range ? filled_r[idx] : 1'b0;
        item_r.ch       <= in_ch;
        item_r.sample   <= in_sample;
        item_r.addr     <= addr;
      end else if (take) begin
        item_r.valid <= 1'b0;
      end
    end
  end

  msr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (take && item_r.in_range),
    .waddr (item_r.addr),
    .wdata (item_r.sample),
    .re    (accept),
    .raddr (addr),
    .rdata (rdata)
  );

  assign item       = item_r;
  assign old_sample = item_r.filled ? $signed(rdata) : '0;

endmodule

// ----- hw/rtl/msr_spike.sv -----
// Running sums, spike check against the accepted sum, and the result register.
// Uses msr_pkg.
module msr_spike (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msr_pkg::msr_item_t                  item,
  input  logic signed [msr_pkg::SAMPLE_W-1:0] old_sample,
  input  logic [msr_pkg::LIMIT_W-1:0]         limit,
  input  logic                                out_ready,
  output logic                                take,
  output logic                                out_valid,
  output logic [msr_pkg::CH_W-1:0]            out_ch,
  output logic signed [msr_pkg::SUM_W-1:0]    out_avg,
  output logic signed [msr_pkg::SUM_W-1:0]    out_filt,
  output logic                                out_rej
);
  import msr_pkg::*;

  logic signed [SUM_W-1:0] wsum_r [CHANNELS];
  logic signed [SUM_W-1:0] asum_r [CHANNELS];
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [SUM_W-1:0] out_avg_r;
  logic signed [SUM_W-1:0] out_filt_r;
  logic                    out_rej_r;

  logic [CH_IDX_W-1:0]      idx;
  logic signed [DIFF_W-1:0] sum_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic                     reject;

  assign idx     = item.ch[CH_IDX_W-1:0];
  assign acc     = asum_r[idx];
  assign sum_ext = DIFF_W'(wsum_r[idx]) - DIFF_W'(old_sample) + DIFF_W'(item.sample);
  assign sum     = sum_ext[SUM_W-1:0];
  assign diff    = DIFF_W'(sum) - DIFF_W'(acc);
  assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign reject  = CMP_W'(mag) > CMP_W'(limit);
  assign take    = item.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wsum_r[i] <= '0;
        asum_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (take && item.in_range) begin
        wsum_r[idx] <= sum;
        if (!reject) begin
          asum_r[idx] <= sum;
        end
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch_r <= item.ch;
      if (item.in_range) begin
        out_avg_r  <= sum;
        out_filt_r <= reject ? acc : sum;
        out_rej_r  <= reject;
      end else begin
        out_avg_r  <= '0;
        out_filt_r <= '0;
        out_rej_r  <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_avg   = out_avg_r;
  assign out_filt  = out_filt_r;
  assign out_rej   = out_rej_r;

endmodule

// ----- bench/moving_average_spike_reject_unit_test.sv -----
// Self-checking bench for the moving average spike reject unit: directed rows, then random bursts.
// Keeps its own per-channel ring, running sums and threshold to predict each result word.
// Depends on msr_pkg and the moving_average_spike_reject_unit top level.
`timescale 1ns / 100ps

module moving_average_spike_reject_unit_test;
  import msr_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef enum {ROW_WORD, ROW_THRESHOLD} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        ch;
    int        value;
    bit        typed;
    int        avg;
    int        filt;
    bit        spk;
  } script_row_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic signed [SUM_W-1:0] avg;
    logic signed [SUM_W-1:0] filt;
    logic                    spk;
  } filter_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [THR_W-1:0]      cfg_data = '0;

  logic signed [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
  int                         ring_head [CHANNELS];
  logic signed [SUM_W-1:0]    ring_total [CHANNELS];
  logic signed [SUM_W-1:0]    held_total [CHANNELS];
  logic [THR_W-1:0]           threshold;

  filter_result_t pending_results [$];
  int failures = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  moving_average_spike_reject_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic filter_result_t filter_word(logic [CH_W-1:0] ch,
                                                 logic signed [SAMPLE_W-1:0] s);
    filter_result_t r;
    int pos;
    int sum;
    int diff;
    r = '0;
    r.ch = ch;
    if (ch >= CHANNELS) return r;
    pos = ring_head[ch];
    sum = int'(ring_total[ch]) - int'(ring[ch][pos]) + int'(s);
    ring[ch][pos] = s;
    ring_head[ch] = (pos + 1 == WINDOW) ? 0 : pos + 1;
    ring_total[ch] = sum;
    diff = sum - int'(held_total[ch]);
    if (diff < 0) diff = -diff;
    r.spk = diff > int'(threshold) * WINDOW;
    if (!r.spk) held_total[ch] = sum;
    r.avg = sum;
    r.filt = held_total[ch];
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [CH_W-1:0] ch,
                                                     logic signed [SAMPLE_W-1:0] s);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[CH_W-1:0] = ch;
    w[CH_W +: SAMPLE_W] = s;
    return w;
  endfunction

  task automatic drive_word(logic [IN_DATA_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] s);
    pending_results.push_back(filter_word(ch, s));
    drive_word(pack_word(ch, s));
  endtask

  task automatic drain;
    if (pending_results.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic set_threshold(int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value[THR_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value[THR_W-1:0];
  endtask

  task automatic run_random(int count);
    int left;
    int kind;
    int ch;
    int len;
    int base;
    int v;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(9);
      ch = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
      len = (kind == 4 || kind == 5) ? $urandom_range(70, 50) : $urandom_range(60, 1);
      base = int'($urandom_range(2047)) - 1024;
      if (kind == 4 || kind == 5) base = $urandom_range(1) ? 1023 : -1024;
      for (int i = 0; i < len && left > 0; i++) begin
        if (kind <= 3) begin
          v = int'($urandom_range(2047)) - 1024;
        end else if (kind <= 5) begin
          v = base;
        end else if (kind <= 8) begin
          v = base + int'($urandom_range(16)) - 8;
          if ($urandom_range(9) == 0) v = int'($urandom_range(2047)) - 1024;
          if (v > 1023) v = 1023;
          if (v < -1024) v = -1024;
        end else begin
          ch = $urandom_range(7);
          v = int'($urandom_range(2047)) - 1024;
        end
        if ($urandom_range(199) == 0) drain();
        send_sample(ch[CH_W-1:0], v[SAMPLE_W-1:0]);
        left--;
      end
    end
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: channel_out %0d", out_tdata[CH_W-1:0]);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[CH_W-1:0] !== want.ch) begin
          $error("channel_out: expected %0d, got %0d", want.ch, out_tdata[CH_W-1:0]);
          failures++;
        end
        if ($signed(out_tdata[CH_W +: SUM_W]) !== want.avg) begin
          $error("average_scaled: expected %0d, got %0d", want.avg,
                 $signed(out_tdata[CH_W +: SUM_W]));
          failures++;
        end
        if ($signed(out_tdata[CH_W+SUM_W +: SUM_W]) !== want.filt) begin
          $error("filtered_scaled: expected %0d, got %0d", want.filt,
                 $signed(out_tdata[CH_W+SUM_W +: SUM_W]));
          failures++;
        end
        if (out_tuser !== want.spk) begin
          $error("spike_rejected: expected %0d, got %0d", want.spk, out_tuser);
          failures++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("moving_average_spike_reject_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    script_row_t script [18];
    filter_result_t want;
    int send_modes [3];
    int recv_modes [3];
    int thr_a [3];
    int thr_b [3];

    script = '{
      '{ROW_WORD, 0, 1023, 1'b1, 1023, 1023, 1'b0},
      '{ROW_WORD, 1, -1024, 1'b1, -1024, -1024, 1'b0},
      '{ROW_WORD, 6, 555, 1'b1, 0, 0, 1'b0},
      '{ROW_WORD, 7, -1, 1'b1, 0, 0, 1'b0},
      '{ROW_WORD, 0, 1023, 1'b1, 2046, 2046, 1'b0},
      '{ROW_THRESHOLD, 0, 0, 1'b0, 0, 0, 1'b0},
      '{ROW_WORD, 2, 0, 1'b1, 0, 0, 1'b0},
      '{ROW_WORD, 2, 1, 1'b1, 1, 0, 1'b1},
      '{ROW_WORD, 2, -1, 1'b1, 0, 0, 1'b0},
      '{ROW_THRESHOLD, 0, 20, 1'b0, 0, 0, 1'b0},
      '{ROW_WORD, 3, 1000, 1'b1, 1000, 1000, 1'b0},
      '{ROW_WORD, 3, 1001, 1'b1, 2001, 1000, 1'b1},
      '{ROW_THRESHOLD, 0, 2047, 1'b0, 0, 0, 1'b0},
      '{ROW_WORD, 4, -1024, 1'b1, -1024, -1024, 1'b0},
      '{ROW_WORD, 5, 1023, 1'b1, 1023, 1023, 1'b0},
      '{ROW_THRESHOLD, 0, 1, 1'b0, 0, 0, 1'b0},
      '{ROW_WORD, 5, -1024, 1'b1, -1, 1023, 1'b1},
      '{ROW_WORD, 1, 512, 1'b0, 0, 0, 1'b0}
    };
    send_modes = '{7, 45, 0};
    recv_modes = '{45, 7, 0};
    thr_a = '{0, 2047, $urandom_range(40, 1)};
    thr_b = '{$urandom_range(60), $urandom_range(2047), 30};

    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WINDOW; k++) ring[c][k] = '0;
      ring_head[c] = 0;
      ring_total[c] = '0;
      held_total[c] = '0;
    end
    threshold = THRESH_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 7;
    recv_idle = 45;
    foreach (script[i]) begin
      if (script[i].kind == ROW_THRESHOLD) begin
        set_threshold(script[i].value);
      end else begin
        want = filter_word(script[i].ch[CH_W-1:0], script[i].value[SAMPLE_W-1:0]);
        if (script[i].typed) begin
          want.ch = script[i].ch[CH_W-1:0];
          want.avg = script[i].avg[SUM_W-1:0];
          want.filt = script[i].filt[SUM_W-1:0];
          want.spk = script[i].spk;
        end
        pending_results.push_back(want);
        drive_word(pack_word(script[i].ch[CH_W-1:0], script[i].value[SAMPLE_W-1:0]));
      end
    end

    for (int m = 0; m < 3; m++) begin
      drain();
      send_idle = send_modes[m];
      recv_idle = recv_modes[m];
      set_threshold(thr_a[m]);
      run_random(175);
      set_threshold(thr_b[m]);
      run_random(175);
    end

    drain();
    repeat (16) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("moving_average_spike_reject_unit regression: pass");
    end else begin
      $display("moving_average_spike_reject_unit regression: fail");
    end
    $finish;
  end

endmodule
